// File: sv/terminal_line_editor_top_defines.svh
// Assertion helpers used by the editor's datapath.
`ifndef TERMINAL_LINE_EDITOR_TOP_DEFINES_SVH
`define TERMINAL_LINE_EDITOR_TOP_DEFINES_SVH

// A condition that holds at every clock edge outside reset.
`define TLE_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// A consequence that must hold in the cycle after its trigger.
`define TLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// A consequence that must hold in the same cycle as its trigger.
`define TLE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: sv/tle_pkg.sv
package tle_pkg;

    typedef enum logic [2:0] {
        ACT_ECHO    = 3'd0,
        ACT_ERASE   = 3'd1,
        ACT_NEWLINE = 3'd2,
        ACT_BELL    = 3'd3,
        ACT_END     = 3'd4
    } t_act;

    typedef enum logic [1:0] {
        LAST_ONE  = 2'd0,
        LAST_ZERO = 2'd1,
        LAST_LEN1 = 2'd2
    } t_last;

    typedef enum logic [1:0] {
        LEN_KEEP = 2'd0,
        LEN_CLR  = 2'd1,
        LEN_INC  = 2'd2,
        LEN_DEC  = 2'd3
    } t_len_op;

    typedef enum logic [2:0] {
        COND_NONE     = 3'd0,
        COND_ALWAYS   = 3'd1,
        COND_LEN_ZERO = 3'd2,
        COND_LEN_NZ   = 3'd3,
        COND_NOT_FULL = 3'd4,
        COND_MARK_SET = 3'd5,
        COND_DISPATCH = 3'd6
    } t_cond;

    localparam int PcW = 4;
    typedef logic [PcW-1:0] t_pc;

    // Microprogram addresses.
    localparam t_pc PC_IDLE  = 4'd0;
    localparam t_pc PC_PRINT = 4'd1;
    localparam t_pc PC_ECHO  = 4'd3;
    localparam t_pc PC_ERASE = 4'd4;
    localparam t_pc PC_KILL  = 4'd6;
    localparam t_pc PC_WORD  = 4'd8;
    localparam t_pc PC_WSPC  = 4'd12;
    localparam t_pc PC_EOF   = 4'd13;
    localparam t_pc PC_BELL  = 4'd15;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_ERASE = 2'd0;
    localparam logic [1:0] REG_KILL  = 2'd1;
    localparam logic [1:0] REG_WERASE = 2'd2;
    localparam logic [1:0] REG_EOF   = 2'd3;

    localparam logic [7:0] CHAR_SPACE = 8'h20;

    typedef struct packed {
        logic [7:0] erase_char;
        logic [7:0] kill_char;
        logic [7:0] word_erase_char;
        logic [7:0] eof_char;
    } t_cfg;

    typedef struct packed {
        logic    emit;
        t_act    act;
        t_last   last_sel;
        t_len_op len_op;
        logic    mark_wr;
        logic    mark_rd;
        logic    set_over;
        t_cond   cond;
        logic    fin;
        t_pc     tgt;
    } t_ctrl;

    typedef struct packed {
        logic len_zero;
        logic len_full;
        logic mark_set;
        logic over;
        logic slot_free;
    } t_status;

    function automatic t_ctrl mk(input logic emit, input t_act act, input t_last ls,
                                 input t_len_op lo, input logic mw, input logic mr,
                                 input logic so, input t_cond cond, input logic fin,
                                 input t_pc tgt);
        t_ctrl c;
        c.emit     = emit;
        c.act      = act;
        c.last_sel = ls;
        c.len_op   = lo;
        c.mark_wr  = mw;
        c.mark_rd  = mr;
        c.set_over = so;
        c.cond     = cond;
        c.fin      = fin;
        c.tgt      = tgt;
        return c;
    endfunction

    // Control store: one word per step.
    function automatic t_ctrl ucode(input t_pc pc);
        t_ctrl c;
        case (pc)
            // Wait for a byte and branch on its class.
            4'd0:  c = mk(1'b0, ACT_ECHO, LAST_ONE, LEN_KEEP, 1'b0, 1'b0, 1'b0,
                          COND_DISPATCH, 1'b0, PC_IDLE);
            // Printable: wrap the line when it is full, then echo.
            4'd1:  c = mk(1'b0, ACT_ECHO, LAST_ONE, LEN_KEEP, 1'b0, 1'b0, 1'b0,
                          COND_NOT_FULL, 1'b0, PC_ECHO);
            4'd2:  c = mk(1'b1, ACT_NEWLINE, LAST_ZERO, LEN_CLR, 1'b0, 1'b0, 1'b0,
                          COND_NONE, 1'b0, PC_IDLE);
            4'd3:  c = mk(1'b1, ACT_ECHO, LAST_ONE, LEN_INC, 1'b1, 1'b0, 1'b0,
                          COND_NONE, 1'b1, PC_IDLE);
            // Erase one character.
            4'd4:  c = mk(1'b0, ACT_ECHO, LAST_ONE, LEN_KEEP, 1'b0, 1'b0, 1'b0,
                          COND_LEN_ZERO, 1'b0, PC_IDLE);
            4'd5:  c = mk(1'b1, ACT_ERASE, LAST_ONE, LEN_DEC, 1'b0, 1'b0, 1'b0,
                          COND_NONE, 1'b1, PC_IDLE);
            // Kill: erase until the line is empty.
            4'd6:  c = mk(1'b0, ACT_ECHO, LAST_ONE, LEN_KEEP, 1'b0, 1'b0, 1'b0,
                          COND_LEN_ZERO, 1'b0, PC_IDLE);
            4'd7:  c = mk(1'b1, ACT_ERASE, LAST_LEN1, LEN_DEC, 1'b0, 1'b0, 1'b0,
                          COND_ALWAYS, 1'b0, PC_KILL);
            // Word erase: drop non-spaces, then a single space.
            4'd8:  c = mk(1'b0, ACT_ECHO, LAST_ONE, LEN_KEEP, 1'b0, 1'b0, 1'b0,
                          COND_LEN_ZERO, 1'b0, PC_IDLE);
            4'd9:  c = mk(1'b0, ACT_ECHO, LAST_ONE, LEN_KEEP, 1'b0, 1'b1, 1'b0,
                          COND_NONE, 1'b0, PC_IDLE);
            4'd10: c = mk(1'b0, ACT_ECHO, LAST_ONE, LEN_KEEP, 1'b0, 1'b0, 1'b0,
                          COND_MARK_SET, 1'b0, PC_WSPC);
            4'd11: c = mk(1'b1, ACT_ERASE, LAST_LEN1, LEN_DEC, 1'b0, 1'b0, 1'b0,
                          COND_ALWAYS, 1'b0, PC_WORD);
            4'd12: c = mk(1'b1, ACT_ERASE, LAST_ONE, LEN_DEC, 1'b0, 1'b0, 1'b0,
                          COND_NONE, 1'b1, PC_IDLE);
            // End of file: only on an empty line.
            4'd13: c = mk(1'b0, ACT_ECHO, LAST_ONE, LEN_KEEP, 1'b0, 1'b0, 1'b0,
                          COND_LEN_NZ, 1'b0, PC_IDLE);
            4'd14: c = mk(1'b1, ACT_END, LAST_ONE, LEN_KEEP, 1'b0, 1'b0, 1'b1,
                          COND_NONE, 1'b1, PC_IDLE);
            // Anything else rings the bell.
            4'd15: c = mk(1'b1, ACT_BELL, LAST_ONE, LEN_KEEP, 1'b0, 1'b0, 1'b0,
                          COND_NONE, 1'b1, PC_IDLE);
            default: c = mk(1'b0, ACT_ECHO, LAST_ONE, LEN_KEEP, 1'b0, 1'b0, 1'b0,
                            COND_NONE, 1'b1, PC_IDLE);
        endcase
        return c;
    endfunction

endpackage

// File: sv/terminal_line_editor_top.sv
// An accepted byte is decoded at the accepting edge and its class routine runs from the
// microprogram's step loop; kill and word erase repeat their steps once per removed column,
// and a new byte is taken only once the routine for the last one has returned to step zero.
// Reset (synchronous, active low) empties the line, clears the session flag, loads the
// default control characters and drops any pending result.
module terminal_line_editor_top #(
    parameter int LINE_LIMIT = 40
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream. tdata[7:0]: char_in.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,
    // Output stream. tdata[7:0]: char_out. tuser[2:0]: action. tlast: last.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,
    output logic [2:0]  o_m_tuser,
    output logic        o_m_tlast,
    // Configuration port: erase, kill, word erase and EOF characters at 0x0, 0x4, 0x8, 0xC.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tle_pkg::*;

    // The sequencer steps through a small control store. Step zero waits for a byte and
    // jumps to the routine for its class; each routine drives the datapath one control
    // word at a time and returns to step zero when its work is done. Steps that emit a
    // result hold while the output register still carries a result that has not been
    // taken, so a stalled consumer freezes the routine in place without losing anything.
    t_cfg       cfg;
    t_ctrl      ctrl;
    t_status    status;
    logic [7:0] seq_char;

    tle_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tle_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .i_char   (i_s_tdata),
        .o_ready  (o_s_tready),
        .i_cfg    (cfg),
        .i_status (status),
        .o_ctrl   (ctrl),
        .o_char   (seq_char)
    );

    // The datapath holds the line length, the per-column space marks in a small
    // memory with a registered read, the session flag and the output register.
    tle_datapath #(
        .LINE_LIMIT (LINE_LIMIT)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (ctrl),
        .i_char   (seq_char),
        .o_status (status),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_act    (o_m_tuser),
        .o_chr    (o_m_tdata),
        .o_last   (o_m_tlast)
    );
endmodule

// File: sv/tle_regs.sv
module tle_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output tle_pkg::t_cfg o_cfg
);
    import tle_pkg::*;

    t_cfg r_cfg;
    logic wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.erase_char      <= 8'd127;
            r_cfg.kill_char       <= 8'd21;
            r_cfg.word_erase_char <= 8'd23;
            r_cfg.eof_char        <= 8'd4;
        end else if (wr) begin
            case (paddr[3:2])
                REG_ERASE:  r_cfg.erase_char      <= pwdata[7:0];
                REG_KILL:   r_cfg.kill_char       <= pwdata[7:0];
                REG_WERASE: r_cfg.word_erase_char <= pwdata[7:0];
                REG_EOF:    r_cfg.eof_char        <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_ERASE:  prdata = {24'd0, r_cfg.erase_char};
            REG_KILL:   prdata = {24'd0, r_cfg.kill_char};
            REG_WERASE: prdata = {24'd0, r_cfg.word_erase_char};
            REG_EOF:    prdata = {24'd0, r_cfg.eof_char};
            default:    prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;
endmodule

// File: sv/tle_seq.sv
module tle_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [7:0]       i_char,
    output logic             o_ready,
    input  tle_pkg::t_cfg    i_cfg,
    input  tle_pkg::t_status i_status,
    output tle_pkg::t_ctrl   o_ctrl,
    output logic [7:0]       o_char
);
    import tle_pkg::*;

    t_pc        r_pc, n_pc;
    logic [7:0] r_char;
    t_ctrl      ctrl;
    t_pc        entry;
    logic       cond_true;
    logic       step_go;
    logic       accept;

    assign ctrl    = ucode(r_pc);
    assign o_ready = (ctrl.cond == COND_DISPATCH);
    assign accept  = o_ready && i_valid;
    assign step_go = !ctrl.emit || i_status.slot_free;

    // Byte class decode; a printable byte wins over any register match.
    always_comb begin
        if (i_status.over) begin
            entry = PC_IDLE;
        end else if (i_char inside {[8'h20:8'h7E]}) begin
            entry = PC_PRINT;
        end else if (i_char == i_cfg.erase_char) begin
            entry = PC_ERASE;
        end else if (i_char == i_cfg.kill_char) begin
            entry = PC_KILL;
        end else if (i_char == i_cfg.word_erase_char) begin
            entry = PC_WORD;
        end else if (i_char == i_cfg.eof_char) begin
            entry = PC_EOF;
        end else begin
            entry = PC_BELL;
        end
    end

    always_comb begin
        case (ctrl.cond)
            COND_ALWAYS:   cond_true = 1'b1;
            COND_LEN_ZERO: cond_true = i_status.len_zero;
            COND_LEN_NZ:   cond_true = !i_status.len_zero;
            COND_NOT_FULL: cond_true = !i_status.len_full;
            COND_MARK_SET: cond_true = i_status.mark_set;
            default:       cond_true = 1'b0;
        endcase
    end

    always_comb begin
        if (ctrl.cond == COND_DISPATCH) begin
            n_pc = accept ? entry : r_pc;
        end else if (!step_go) begin
            n_pc = r_pc;
        end else if (ctrl.fin) begin
            n_pc = PC_IDLE;
        end else if (cond_true) begin
            n_pc = ctrl.tgt;
        end else begin
            n_pc = r_pc + t_pc'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_char <= i_char;
        end
    end

    assign o_ctrl = ctrl;
    assign o_char = r_char;
endmodule

// File: sv/tle_datapath.sv
module tle_datapath #(
    parameter int LINE_LIMIT = 40
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tle_pkg::t_ctrl   i_ctrl,
    input  logic [7:0]       i_char,
    output tle_pkg::t_status o_status,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [2:0]       o_act,
    output logic [7:0]       o_chr,
    output logic             o_last
);
    import tle_pkg::*;
    `include "terminal_line_editor_top_defines.svh"

    localparam int LenW = $clog2(LINE_LIMIT);

    logic [LenW-1:0] r_len, n_len;
    logic            r_mark [LINE_LIMIT];
    logic            r_mark_q;
    logic            r_over;
    logic            r_out_valid;
    t_act            r_act;
    logic [7:0]      r_chr;
    logic            r_last;
    logic            slot_free;
    logic            step_go;
    logic            last_val;
    logic [LenW-1:0] len_m1;

    assign slot_free = !r_out_valid || i_ready;
    assign step_go   = !i_ctrl.emit || slot_free;
    assign len_m1    = r_len - LenW'(1);

    always_comb begin
        case (i_ctrl.len_op)
            LEN_CLR: n_len = '0;
            LEN_INC: n_len = r_len + LenW'(1);
            LEN_DEC: n_len = len_m1;
            default: n_len = r_len;
        endcase
    end

    always_comb begin
        case (i_ctrl.last_sel)
            LAST_ONE:  last_val = 1'b1;
            LAST_ZERO: last_val = 1'b0;
            LAST_LEN1: last_val = (r_len == LenW'(1));
            default:   last_val = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_over      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (step_go) begin
                r_len <= n_len;
                if (i_ctrl.set_over) begin
                    r_over <= 1'b1;
                end
            end
            if (step_go && i_ctrl.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_go && i_ctrl.emit) begin
            r_act  <= i_ctrl.act;
            r_chr  <= (i_ctrl.act == ACT_ECHO) ? i_char : 8'd0;
            r_last <= last_val;
        end
    end

    // Space marks, one per column, with a registered read port.
    always_ff @(posedge i_clk) begin
        if (step_go && i_ctrl.mark_wr) begin
            r_mark[r_len] <= (i_char == CHAR_SPACE);
        end
        if (i_ctrl.mark_rd) begin
            r_mark_q <= r_mark[len_m1];
        end
    end

    assign o_status.len_zero  = (r_len == '0);
    assign o_status.len_full  = (r_len >= LenW'(LINE_LIMIT - 1));
    assign o_status.mark_set  = r_mark_q;
    assign o_status.over      = r_over;
    assign o_status.slot_free = slot_free;

    assign o_valid = r_out_valid;
    assign o_act   = r_act;
    assign o_chr   = r_chr;
    assign o_last  = r_last;

    `TLE_ASSERT_ALWAYS(a_len_range, r_len <= LenW'(LINE_LIMIT - 1), "line length out of range")
    `TLE_ASSERT_SAME(a_dec_nonempty, step_go && i_ctrl.len_op == LEN_DEC, r_len != '0, "erase on empty line")
    `TLE_ASSERT_NEXT(a_emit_shown, step_go && i_ctrl.emit, r_out_valid, "emitted result not presented")
    `TLE_ASSERT_SAME(a_write_in_range, step_go && i_ctrl.mark_wr, r_len < LenW'(LINE_LIMIT - 1), "mark write at full line")
endmodule

// File: tb/terminal_line_editor_top_tb.sv
module terminal_line_editor_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tle_pkg::*;

    // The line width the block is built with. The predictor uses the same value.
    localparam int LINE_LIMIT = 40;

    // Default control keys, the values the registers hold after reset.
    localparam logic [7:0] DEF_ERASE  = 8'h7F;
    localparam logic [7:0] DEF_KILL   = 8'h15;
    localparam logic [7:0] DEF_WERASE = 8'h17;
    localparam logic [7:0] DEF_EOF    = 8'h04;

    // Cycles allowed after the last expected result before the block counts as idle.
    // Bytes that produce no output still spend a few microprogram steps.
    localparam int SETTLE_CYCLES  = 16;
    // Length of the long receiver hold-off that fills the block and stalls its input.
    localparam int HOLD_CYCLES    = 400;
    // Cycles with no transaction on any port before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 4000;
    // Least number of random bytes typed in each phase; a burst may run past it.
    localparam int PHASE_ITEMS    = 85;
    localparam int N_PHASES       = 5;

    // One expected output transaction.
    typedef struct packed {
        t_act       act;
        logic [7:0] ch;
        logic       last;
    } t_res;

    // One row of the stimulus table. Rows with typed set carry their own expectation:
    // a single result when one is set, no result otherwise. All other rows are checked
    // against the predictor.
    typedef struct packed {
        logic [7:0] key;
        logic       typed;
        logic       one;
        t_act       act;
        logic [7:0] ch;
    } t_row;

    // Rows 0 to 23 run right after reset with the default keys. Rows 24 onward close
    // the run: they empty the line, end the session and show that later bytes are ignored.
    localparam int N_ROWS    = 29;
    localparam int TAIL_ROW  = 24;
    localparam t_row KEY_ROWS [N_ROWS] = '{
        // Editing keys on the empty line produce nothing.
        '{DEF_ERASE,  1'b1, 1'b0, ACT_ECHO,  8'h00},
        '{DEF_KILL,   1'b1, 1'b0, ACT_ECHO,  8'h00},
        '{DEF_WERASE, 1'b1, 1'b0, ACT_ECHO,  8'h00},
        // Both ends of the byte range ring the bell.
        '{8'h00,      1'b1, 1'b1, ACT_BELL,  8'h00},
        '{8'hFF,      1'b1, 1'b1, ACT_BELL,  8'h00},
        // Both ends of the printable range are echoed.
        '{8'h20,      1'b1, 1'b1, ACT_ECHO,  8'h20},
        '{8'h7E,      1'b1, 1'b1, ACT_ECHO,  8'h7E},
        // EOF on a line that holds characters is dropped silently.
        '{DEF_EOF,    1'b1, 1'b0, ACT_ECHO,  8'h00},
        '{DEF_ERASE,  1'b1, 1'b1, ACT_ERASE, 8'h00},
        // Just below the printable range, and just above the erase key.
        '{8'h1F,      1'b1, 1'b1, ACT_BELL,  8'h00},
        '{8'h80,      1'b1, 1'b1, ACT_BELL,  8'h00},
        '{8'h61,      1'b1, 1'b1, ACT_ECHO,  8'h61},
        // Build " ab cd" and take it apart one word at a time.
        '{8'h62,      1'b0, 1'b0, ACT_ECHO,  8'h00},
        '{8'h20,      1'b0, 1'b0, ACT_ECHO,  8'h00},
        '{8'h63,      1'b0, 1'b0, ACT_ECHO,  8'h00},
        '{8'h64,      1'b0, 1'b0, ACT_ECHO,  8'h00},
        '{DEF_WERASE, 1'b0, 1'b0, ACT_ECHO,  8'h00},
        '{DEF_WERASE, 1'b0, 1'b0, ACT_ECHO,  8'h00},
        // A word erase with no space in front of the word stops at column zero.
        '{8'h78,      1'b0, 1'b0, ACT_ECHO,  8'h00},
        '{8'h79,      1'b0, 1'b0, ACT_ECHO,  8'h00},
        '{DEF_WERASE, 1'b0, 1'b0, ACT_ECHO,  8'h00},
        '{8'h71,      1'b0, 1'b0, ACT_ECHO,  8'h00},
        '{8'h72,      1'b0, 1'b0, ACT_ECHO,  8'h00},
        '{DEF_KILL,   1'b0, 1'b0, ACT_ECHO,  8'h00},
        // Closing rows: empty the line, end the session, then nothing answers.
        '{DEF_KILL,   1'b0, 1'b0, ACT_ECHO,  8'h00},
        '{DEF_EOF,    1'b1, 1'b1, ACT_END,   8'h00},
        '{8'h41,      1'b1, 1'b0, ACT_ECHO,  8'h00},
        '{DEF_EOF,    1'b1, 1'b0, ACT_ECHO,  8'h00},
        '{DEF_ERASE,  1'b1, 1'b0, ACT_ECHO,  8'h00}
    };

    // Key settings per random phase. Phase 1 uses the extremes 0x00 and 0xFF, phase 2
    // makes keys equal so that decode priority decides, phase 3 puts the erase key on a
    // printable byte, and the last phase returns to the defaults for the closing rows.
    localparam t_cfg PHASE_KEYS [N_PHASES] = '{
        '{DEF_ERASE, DEF_KILL, DEF_WERASE, DEF_EOF},
        '{8'h08,     8'h00,    8'hFF,      8'h1A},
        '{8'hFF,     8'hFF,    8'h00,      8'h00},
        '{8'h41,     8'h15,    8'h17,      8'h7F},
        '{DEF_ERASE, DEF_KILL, DEF_WERASE, DEF_EOF}
    };
    // Percent of cycles in which the sender idles and the receiver stalls, per phase.
    localparam int PHASE_GAP   [N_PHASES] = '{0, 53, 0, 26, 0};
    localparam int PHASE_STALL [N_PHASES] = '{0, 0, 53, 26, 0};

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;     // [7:0] char_in
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [7:0]  o_m_tdata;     // [7:0] char_out
    logic [2:0]  o_m_tuser;     // [2:0] action
    logic        o_m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Predictor state: the line as the block should see it, plus a copy of the keys.
    logic [5:0]  line_len;
    logic        space_col [LINE_LIMIT];
    logic        ended;
    logic [7:0]  erase_key;
    logic [7:0]  kill_key;
    logic [7:0]  werase_key;
    logic [7:0]  eof_key;

    // Results of the byte being predicted, and all terminal output still owed by the block.
    t_res        fresh [$];
    t_res        echo_due [$];

    int          n_fail;
    int          tx_gap_pct;
    int          rx_stall_pct;
    logic        hold_on;
    int          quiet_cycles;

    terminal_line_editor_top #(
        .LINE_LIMIT (LINE_LIMIT)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic is_printable(input logic [7:0] c);
        return (c >= 8'h20) && (c <= 8'h7E);
    endfunction

    function automatic void emit_res(input t_act a, input logic [7:0] ch);
        fresh.push_back('{a, ch, 1'b0});
    endfunction

    function automatic void drop_col();
        line_len = line_len - 1'b1;
        emit_res(ACT_ERASE, 8'h00);
    endfunction

    // Works out the terminal output for one typed byte and advances the line state.
    // Printable bytes win over any key register; after that erase, kill, word erase
    // and EOF are tried in that order, and whatever is left rings the bell.
    function automatic void edit_line(input logic [7:0] c);
        t_res tail_res;
        fresh.delete();
        if (!ended) begin
            if (is_printable(c)) begin
                // A full line wraps before the new character is echoed.
                if (line_len >= LINE_LIMIT - 1) begin
                    emit_res(ACT_NEWLINE, 8'h00);
                    line_len = '0;
                end
                emit_res(ACT_ECHO, c);
                space_col[line_len] = (c == CHAR_SPACE);
                line_len = line_len + 1'b1;
            end else if (c == erase_key) begin
                if (line_len != 0)
                    drop_col();
            end else if (c == kill_key) begin
                while (line_len != 0)
                    drop_col();
            end else if (c == werase_key) begin
                // Strip the word, then the single space in front of it if there is one.
                while (line_len != 0 && !space_col[line_len - 1])
                    drop_col();
                if (line_len != 0)
                    drop_col();
            end else if (c == eof_key) begin
                if (line_len == 0) begin
                    emit_res(ACT_END, 8'h00);
                    ended = 1'b1;
                end
            end else begin
                emit_res(ACT_BELL, 8'h00);
            end
        end
        if (fresh.size() > 0) begin
            tail_res = fresh.pop_back();
            tail_res.last = 1'b1;
            fresh.push_back(tail_res);
        end
    endfunction

    // True when the byte would close the session. The random part must not do that,
    // because reset is applied only once and the closing rows need a live session.
    function automatic logic would_end(input logic [7:0] c);
        return !ended && !is_printable(c) && c != erase_key && c != kill_key &&
               c != werase_key && c == eof_key && line_len == 0;
    endfunction

    // Offers one byte on the input stream and records its expected output once the
    // transaction completes. tvalid is left high; the caller lowers it after the last byte.
    task automatic send_char(input t_row r);
        while (tx_gap_pct > 0 && $urandom_range(99) < tx_gap_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= r.key;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        edit_line(r.key);
        if (r.typed) begin
            fresh.delete();
            if (r.one)
                fresh.push_back('{r.act, r.ch, 1'b1});
        end
        foreach (fresh[k])
            echo_due.push_back(fresh[k]);
    endtask

    // One register write: a setup phase, then an access phase held until pready,
    // then an idle bus. The upper data bits carry junk, since only the
    // low byte is a key.
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'($urandom_range(32'h00FF_FFFF)), val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_ERASE:  erase_key  = val;
            REG_KILL:   kill_key   = val;
            REG_WERASE: werase_key = val;
            REG_EOF:    eof_key    = val;
            default:    ;
        endcase
    endtask

    // Waits for every owed result, then for the steps a silent byte may still take.
    task automatic wait_drained();
        while (echo_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Random typing: bursts of printable text, mostly short but some long enough to
    // wrap the line, each followed by one to three editing keys or noise bytes.
    task automatic type_bursts(input int n_items);
        int         sent;
        int         len;
        int         pick;
        logic [7:0] c;
        sent = 0;
        while (sent < n_items) begin
            len = ($urandom_range(3) == 0) ? $urandom_range(20, 50) : $urandom_range(0, 8);
            repeat (len) begin
                if ($urandom_range(5) == 0)
                    c = CHAR_SPACE;
                else
                    c = 8'($urandom_range(8'h21, 8'h7E));
                send_char('{c, 1'b0, 1'b0, ACT_ECHO, 8'h00});
                sent++;
            end
            repeat ($urandom_range(1, 3)) begin
                pick = $urandom_range(99);
                if (pick < 25)
                    c = erase_key;
                else if (pick < 40)
                    c = kill_key;
                else if (pick < 70)
                    c = werase_key;
                else if (pick < 80)
                    c = eof_key;
                else
                    c = 8'($urandom_range(255));
                // Swap a session-ending EOF for the erase key, silent on an empty line unless that key is printable.
                if (would_end(c))
                    c = erase_key;
                send_char('{c, 1'b0, 1'b0, ACT_ECHO, 8'h00});
                sent++;
            end
        end
    endtask

    // Output side: randomly stalls tready, obeys the long hold-off, and checks every
    // output transaction against the oldest owed result.
    always @(posedge i_clk) begin : rx_side
        t_res want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (echo_due.size() == 0) begin
                $display("%0t: unexpected output: expected nothing,", $time,
                         " got action %0d byte %02h last %0b",
                         o_m_tuser, o_m_tdata, o_m_tlast);
                n_fail++;
            end else begin
                want = echo_due.pop_front();
                if (o_m_tuser !== want.act || o_m_tdata !== want.ch ||
                    o_m_tlast !== want.last) begin
                    $display("%0t: output mismatch: expected action %0d byte %02h last %0b,",
                             $time, want.act, want.ch, want.last,
                             " got action %0d byte %02h last %0b",
                             o_m_tuser, o_m_tdata, o_m_tlast);
                    n_fail++;
                end
            end
        end
        i_m_tready <= !hold_on && !(rx_stall_pct > 0 && $urandom_range(99) < rx_stall_pct);
    end

    // Ends a run that stops moving: no transaction on either stream or the register port.
    always @(posedge i_clk) begin : watchdog
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d results still owed",
                     $time, quiet_cycles, echo_due.size());
            $display("FAIL terminal_line_editor_top");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int p;
        int k;
        i_rst_n      = 1'b0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = 8'h00;
        i_m_tready   = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        hold_on      = 1'b0;
        quiet_cycles = 0;
        n_fail       = 0;
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        line_len     = '0;
        ended        = 1'b0;
        erase_key    = DEF_ERASE;
        kill_key     = DEF_KILL;
        werase_key   = DEF_WERASE;
        eof_key      = DEF_EOF;
        foreach (space_col[k])
            space_col[k] = 1'b0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows with the reset keys and no idling on either side.
        for (k = 0; k < TAIL_ROW; k++)
            send_char(KEY_ROWS[k]);
        i_s_tvalid <= 1'b0;

        // Random phases. Keys change only once the block has gone quiet.
        for (p = 0; p < N_PHASES; p++) begin
            wait_drained();
            tx_gap_pct   = PHASE_GAP[p];
            rx_stall_pct = PHASE_STALL[p];
            write_reg(REG_ERASE,  PHASE_KEYS[p].erase_char);
            write_reg(REG_KILL,   PHASE_KEYS[p].kill_char);
            write_reg(REG_WERASE, PHASE_KEYS[p].word_erase_char);
            write_reg(REG_EOF,    PHASE_KEYS[p].eof_char);
            // In the first stalling phase the receiver also holds off for a long stretch
            // while typing goes on, so the block backs up and stops taking bytes.
            if (p == 2) begin
                fork
                    begin
                        hold_on <= 1'b1;
                        repeat (HOLD_CYCLES) @(posedge i_clk);
                        hold_on <= 1'b0;
                    end
                join_none
            end
            type_bursts(PHASE_ITEMS);
            i_s_tvalid <= 1'b0;
        end

        // The last phase restored the default keys, which the closing rows rely on.
        for (k = TAIL_ROW; k < N_ROWS; k++)
            send_char(KEY_ROWS[k]);
        i_s_tvalid <= 1'b0;
        wait_drained();

        if (n_fail == 0)
            $display("PASS terminal_line_editor_top");
        else
            $display("FAIL terminal_line_editor_top");
        $finish;
    end

endmodule
